// ===== rtl/dvwq_pkg.sv =====
package dvwq_pkg;

  // input actions
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_FLUSH   = 1'b1;

  // command kinds on the input
  localparam logic [2:0] KIND_POS    = 3'd0;
  localparam logic [2:0] KIND_SHRINK = 3'd1;
  localparam logic [2:0] KIND_HIDE   = 3'd2;
  localparam logic [2:0] KIND_RAW    = 3'd3;
  localparam logic [2:0] KIND_PAL    = 3'd4;

  // command kinds as kept in the sprite command store
  localparam logic [1:0] ENT_POS    = 2'd0;
  localparam logic [1:0] ENT_SHRINK = 2'd1;
  localparam logic [1:0] ENT_HIDE   = 2'd2;
  localparam logic [1:0] ENT_RAW    = 2'd3;

  // result kinds
  localparam logic [1:0] OUT_ACK   = 2'd0;
  localparam logic [1:0] OUT_WRITE = 2'd1;
  localparam logic [1:0] OUT_COPY  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SHRINK_BASE   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_Y_BASE = 2'd1;
  localparam logic [1:0] CFG_X_BASE        = 2'd2;
  localparam logic [1:0] CFG_PALETTE_BASE  = 2'd3;

  // configuration reset values
  localparam logic [15:0] RST_SHRINK_BASE   = 16'h8000;
  localparam logic [15:0] RST_HEIGHT_Y_BASE = 16'h8200;
  localparam logic [15:0] RST_X_BASE        = 16'h8400;
  localparam logic [31:0] RST_PALETTE_BASE  = 32'h0040_0000;

  // palette entry size is 32 bytes
  localparam int PAL_SHIFT = 5;

  typedef struct packed {
    logic        action;
    logic [2:0]  cmd_kind;
    logic [15:0] sprite_slot;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [7:0]  palette_index;
    logic [31:0] source_addr;
  } request_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic [31:0] copy_dest;
    logic [31:0] copy_src;
    logic        accepted;
    logic [4:0]  cmd_free;
    logic [3:0]  pal_free;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] slot;
    logic [15:0] word_a;
    logic [15:0] word_b;
  } cmd_entry_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] src;
  } pal_entry_t;

  // job handed from the front to the back
  typedef struct packed {
    logic       flush;
    logic       accepted;
    logic [4:0] cmd_free;
    logic [3:0] pal_free;
  } job_t;

  typedef struct packed {
    logic [15:0] shrink_base;
    logic [15:0] height_y_base;
    logic [15:0] x_base;
    logic [31:0] palette_base;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CMD_RD,
    BK_CMD_WR,
    BK_CMD_WR2,
    BK_PAL_RD,
    BK_PAL_WR,
    BK_ACK
  } back_state_t;

endpackage

// ===== rtl/dvwq_ram.sv =====
module dvwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dvwq_fifo.sv =====
module dvwq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : AW'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : AW'(rptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

// ===== rtl/dvwq_front.sv =====
module dvwq_front #(
  parameter int CMD_DEPTH = 16,
  parameter int PAL_DEPTH = 8,
  parameter int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1,
  parameter int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1,
  parameter int CMD_CW    = $clog2(CMD_DEPTH + 1),
  parameter int PAL_CW    = $clog2(PAL_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dvwq_pkg::request_t  request,
  output logic                full,
  output logic                job_push,
  output dvwq_pkg::job_t      job,
  input  logic                job_full,
  input  logic                flush_done,
  output logic                cmd_we,
  output logic [CMD_AW-1:0]   cmd_waddr,
  output dvwq_pkg::cmd_entry_t cmd_wdata,
  output logic                pal_we,
  output logic [PAL_AW-1:0]   pal_waddr,
  output dvwq_pkg::pal_entry_t pal_wdata,
  output logic [CMD_CW-1:0]   cmd_count,
  output logic [PAL_CW-1:0]   pal_count
);

  import dvwq_pkg::*;

  localparam logic [CMD_CW-1:0] CMD_FULL = CMD_CW'(CMD_DEPTH);
  localparam logic [PAL_CW-1:0] PAL_FULL = PAL_CW'(PAL_DEPTH);

  logic              busy;
  logic              take;
  logic              is_cmd;
  logic              is_pal;
  logic [CMD_CW-1:0] cmd_count_next;
  logic [PAL_CW-1:0] pal_count_next;
  logic [CMD_CW-1:0] cmd_free_cnt;
  logic [PAL_CW-1:0] pal_free_cnt;

  // hold off new items while a flush drains the stores or the job queue is full
  assign full = busy || job_full;
  assign take = push && !full;

  // classify the item
  assign is_cmd = (request.action == ACT_ENQUEUE) && (request.cmd_kind <= KIND_RAW);
  assign is_pal = (request.action == ACT_ENQUEUE) && (request.cmd_kind == KIND_PAL);
  assign cmd_we = take && is_cmd && (cmd_count != CMD_FULL);
  assign pal_we = take && is_pal && (pal_count != PAL_FULL) && (request.source_addr != '0);

  // store writes at the current fill position
  assign cmd_waddr = cmd_count[CMD_AW-1:0];
  assign pal_waddr = pal_count[PAL_AW-1:0];
  assign cmd_wdata = '{kind:   request.cmd_kind[1:0],
                       slot:   request.sprite_slot,
                       word_a: request.word_a,
                       word_b: request.word_b};
  assign pal_wdata = '{index: request.palette_index, src: request.source_addr};

  // fill counts after this item, cleared when a flush is done
  always_comb begin
    cmd_count_next = cmd_count;
    pal_count_next = pal_count;
    if (flush_done) begin
      cmd_count_next = '0;
      pal_count_next = '0;
    end else begin
      if (cmd_we) begin
        cmd_count_next = CMD_CW'(cmd_count + 1'b1);
      end
      if (pal_we) begin
        pal_count_next = PAL_CW'(pal_count + 1'b1);
      end
    end
  end

  assign cmd_free_cnt = CMD_FULL - cmd_count_next;
  assign pal_free_cnt = PAL_FULL - pal_count_next;

  // job for the back part
  always_comb begin
    job_push = take;
    if (request.action == ACT_FLUSH) begin
      job = '{flush: 1'b1, accepted: 1'b0,
              cmd_free: 5'(CMD_DEPTH), pal_free: 4'(PAL_DEPTH)};
    end else begin
      job = '{flush: 1'b0, accepted: cmd_we || pal_we,
              cmd_free: 5'(cmd_free_cnt), pal_free: 4'(pal_free_cnt)};
    end
  end

  // counts and flush hold
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_count <= '0;
      pal_count <= '0;
      busy      <= 1'b0;
    end else begin
      cmd_count <= cmd_count_next;
      pal_count <= pal_count_next;
      if (flush_done) begin
        busy <= 1'b0;
      end else if (take && request.action == ACT_FLUSH) begin
        busy <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dvwq_back.sv =====
module dvwq_back #(
  parameter int CMD_DEPTH = 16,
  parameter int PAL_DEPTH = 8,
  parameter int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1,
  parameter int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1,
  parameter int CMD_CW    = $clog2(CMD_DEPTH + 1),
  parameter int PAL_CW    = $clog2(PAL_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dvwq_pkg::cfg_t       cfg,
  input  logic                 job_empty,
  input  dvwq_pkg::job_t       job,
  output logic                 job_pop,
  input  logic [CMD_CW-1:0]    cmd_count,
  input  logic [PAL_CW-1:0]    pal_count,
  output logic                 cmd_re,
  output logic [CMD_AW-1:0]    cmd_raddr,
  input  dvwq_pkg::cmd_entry_t cmd_rdata,
  output logic                 pal_re,
  output logic [PAL_AW-1:0]    pal_raddr,
  input  dvwq_pkg::pal_entry_t pal_rdata,
  output logic                 out_push,
  output dvwq_pkg::result_t    out_data,
  input  logic                 out_full,
  output logic                 flush_done
);

  import dvwq_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [CMD_CW-1:0] cidx;
  logic [PAL_CW-1:0] pidx;
  job_t              flush_job;
  logic              cmd_last;
  logic              pal_last;
  logic              cmd_adv;
  logic              pal_adv;

  assign cmd_raddr = cidx[CMD_AW-1:0];
  assign pal_raddr = pidx[PAL_AW-1:0];
  assign cmd_last  = (CMD_CW'(cidx + 1'b1) == cmd_count);
  assign pal_last  = (PAL_CW'(pidx + 1'b1) == pal_count);

  // an entry is finished when its final write or copy goes out
  assign cmd_adv = !out_full &&
                   ((state == BK_CMD_WR && cmd_rdata.kind != ENT_POS) ||
                    state == BK_CMD_WR2);
  assign pal_adv = !out_full && (state == BK_PAL_WR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!job_empty && job.flush) begin
          if (cmd_count != '0) begin
            state_next = BK_CMD_RD;
          end else if (pal_count != '0) begin
            state_next = BK_PAL_RD;
          end else begin
            state_next = BK_ACK;
          end
        end
      end
      BK_CMD_RD: state_next = BK_CMD_WR;
      BK_CMD_WR, BK_CMD_WR2: begin
        if (!out_full) begin
          if (state == BK_CMD_WR && cmd_rdata.kind == ENT_POS) begin
            state_next = BK_CMD_WR2;
          end else if (!cmd_last) begin
            state_next = BK_CMD_RD;
          end else if (pal_count != '0) begin
            state_next = BK_PAL_RD;
          end else begin
            state_next = BK_ACK;
          end
        end
      end
      BK_PAL_RD: state_next = BK_PAL_WR;
      BK_PAL_WR: begin
        if (!out_full) begin
          state_next = pal_last ? BK_ACK : BK_PAL_RD;
        end
      end
      BK_ACK: begin
        if (!out_full) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    job_pop    = 1'b0;
    cmd_re     = 1'b0;
    pal_re     = 1'b0;
    out_push   = 1'b0;
    out_data   = '0;
    flush_done = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          if (job.flush) begin
            job_pop = 1'b1;
          end else if (!out_full) begin
            job_pop           = 1'b1;
            out_push          = 1'b1;
            out_data.out_kind = OUT_ACK;
            out_data.accepted = job.accepted;
            out_data.cmd_free = job.cmd_free;
            out_data.pal_free = job.pal_free;
            out_data.last     = 1'b1;
          end
        end
      end
      BK_CMD_RD: cmd_re = 1'b1;
      BK_CMD_WR: begin
        out_push          = !out_full;
        out_data.out_kind = OUT_WRITE;
        unique case (cmd_rdata.kind)
          ENT_POS: begin
            out_data.write_addr = cfg.height_y_base + cmd_rdata.slot;
            out_data.write_data = cmd_rdata.word_a;
          end
          ENT_SHRINK: begin
            out_data.write_addr = cfg.shrink_base + cmd_rdata.slot;
            out_data.write_data = cmd_rdata.word_a;
          end
          ENT_HIDE: begin
            out_data.write_addr = cfg.height_y_base + cmd_rdata.slot;
            out_data.write_data = '0;
          end
          ENT_RAW: begin
            out_data.write_addr = cmd_rdata.word_a;
            out_data.write_data = cmd_rdata.word_b;
          end
          default: begin
            out_data.write_addr = cmd_rdata.word_a;
            out_data.write_data = cmd_rdata.word_b;
          end
        endcase
      end
      BK_CMD_WR2: begin
        out_push            = !out_full;
        out_data.out_kind   = OUT_WRITE;
        out_data.write_addr = cfg.x_base + cmd_rdata.slot;
        out_data.write_data = cmd_rdata.word_b;
      end
      BK_PAL_RD: pal_re = 1'b1;
      BK_PAL_WR: begin
        out_push           = !out_full;
        out_data.out_kind  = OUT_COPY;
        out_data.copy_dest = cfg.palette_base + {19'd0, pal_rdata.index, 5'd0};
        out_data.copy_src  = pal_rdata.src;
      end
      BK_ACK: begin
        out_push          = !out_full;
        flush_done        = !out_full;
        out_data.out_kind = OUT_ACK;
        out_data.accepted = flush_job.accepted;
        out_data.cmd_free = flush_job.cmd_free;
        out_data.pal_free = flush_job.pal_free;
        out_data.last     = 1'b1;
      end
      default: ;
    endcase
  end

  // state and entry indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cidx  <= '0;
      pidx  <= '0;
    end else begin
      state <= state_next;
      if (state == BK_IDLE) begin
        cidx <= '0;
        pidx <= '0;
      end else begin
        if (cmd_adv && !cmd_last) begin
          cidx <= CMD_CW'(cidx + 1'b1);
        end
        if (pal_adv && !pal_last) begin
          pidx <= PAL_CW'(pidx + 1'b1);
        end
      end
    end
  end

  // flush job kept for its closing acknowledgement
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && !job_empty && job.flush) begin
      flush_job <= job;
    end
  end

endmodule

// ===== rtl/deferred_video_write_queue_unit.sv =====
// Deferred video write queue.
// Items enter on request/push while full is low; results leave on result
// while empty is low and are taken with pop. Configuration registers are
// written on cfg_index/cfg_data when cfg_valid is high (cfg_ready is always
// high); write them only while the block is idle.
// An enqueue gives one acknowledgement, passed through the job queue and the
// result queue; the next item may follow in the cycle after its transfer.
// A flush is taken from the job queue, then walks the sprite command store
// and then the palette store, one store read per entry: a read and a write
// state per shrink, hide or raw write entry, plus a second write state for
// a position entry; a read and a copy state per palette copy; then the
// closing acknowledgement. full stays high from the flush transfer until that acknowledgement is queued.
// A short job queue parts the front (accept, classify, store) from the back
// (result sequencer); a two-entry result queue parts the back from the
// receiver. When the receiver stalls, the result queue fills, the back
// waits, and the job queue then raises full.
// Reset empties both command stores, both queues and restores the
// configuration registers to their defaults.
module deferred_video_write_queue_unit #(
  parameter int CMD_DEPTH = 16,
  parameter int PAL_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dvwq_pkg::request_t request,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output dvwq_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import dvwq_pkg::*;

  localparam int CMD_AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int PAL_AW = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
  localparam int CMD_CW = $clog2(CMD_DEPTH + 1);
  localparam int PAL_CW = $clog2(PAL_DEPTH + 1);
  localparam int JOB_W  = $bits(job_t);
  localparam int RES_W  = $bits(result_t);

  cfg_t              cfg;
  job_t              job_in;
  job_t              job_out;
  logic [JOB_W-1:0]  job_rdata;
  logic              job_push;
  logic              job_pop;
  logic              job_full;
  logic              job_empty;
  logic              flush_done;
  logic              cmd_we;
  logic [CMD_AW-1:0] cmd_waddr;
  cmd_entry_t        cmd_wdata;
  logic              cmd_re;
  logic [CMD_AW-1:0] cmd_raddr;
  logic [$bits(cmd_entry_t)-1:0] cmd_rdata;
  logic              pal_we;
  logic [PAL_AW-1:0] pal_waddr;
  pal_entry_t        pal_wdata;
  logic              pal_re;
  logic [PAL_AW-1:0] pal_raddr;
  logic [$bits(pal_entry_t)-1:0] pal_rdata;
  logic [CMD_CW-1:0] cmd_count;
  logic [PAL_CW-1:0] pal_count;
  logic              out_push;
  result_t           out_data;
  logic              out_full;
  logic [RES_W-1:0]  res_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shrink_base   <= RST_SHRINK_BASE;
      cfg.height_y_base <= RST_HEIGHT_Y_BASE;
      cfg.x_base        <= RST_X_BASE;
      cfg.palette_base  <= RST_PALETTE_BASE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHRINK_BASE:   cfg.shrink_base   <= cfg_data[15:0];
        CFG_HEIGHT_Y_BASE: cfg.height_y_base <= cfg_data[15:0];
        CFG_X_BASE:        cfg.x_base        <= cfg_data[15:0];
        CFG_PALETTE_BASE:  cfg.palette_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and classify
  dvwq_front #(
    .CMD_DEPTH (CMD_DEPTH),
    .PAL_DEPTH (PAL_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .request    (request),
    .full       (full),
    .job_push   (job_push),
    .job        (job_in),
    .job_full   (job_full),
    .flush_done (flush_done),
    .cmd_we     (cmd_we),
    .cmd_waddr  (cmd_waddr),
    .cmd_wdata  (cmd_wdata),
    .pal_we     (pal_we),
    .pal_waddr  (pal_waddr),
    .pal_wdata  (pal_wdata),
    .cmd_count  (cmd_count),
    .pal_count  (pal_count)
  );

  // sprite command and palette stores
  dvwq_ram #(
    .WIDTH ($bits(cmd_entry_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (cmd_waddr),
    .wdata (cmd_wdata),
    .re    (cmd_re),
    .raddr (cmd_raddr),
    .rdata (cmd_rdata)
  );

  dvwq_ram #(
    .WIDTH ($bits(pal_entry_t)),
    .DEPTH (PAL_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // job queue between front and back
  dvwq_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  assign job_out = job_t'(job_rdata);

  // back: result sequencer
  dvwq_back #(
    .CMD_DEPTH (CMD_DEPTH),
    .PAL_DEPTH (PAL_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_empty  (job_empty),
    .job        (job_out),
    .job_pop    (job_pop),
    .cmd_count  (cmd_count),
    .pal_count  (pal_count),
    .cmd_re     (cmd_re),
    .cmd_raddr  (cmd_raddr),
    .cmd_rdata  (cmd_entry_t'(cmd_rdata)),
    .pal_re     (pal_re),
    .pal_raddr  (pal_raddr),
    .pal_rdata  (pal_entry_t'(pal_rdata)),
    .out_push   (out_push),
    .out_data   (out_data),
    .out_full   (out_full),
    .flush_done (flush_done)
  );

  // result queue toward the receiver
  dvwq_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_data),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = result_t'(res_rdata);

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dvwq_pkg::*;

  localparam int CMD_SLOTS   = 16;
  localparam int PAL_SLOTS   = 8;
  localparam int PHASE_ITEMS = 52;
  localparam int MAX_SHOWN   = 10;

  // one row of the directed stimulus, repeated reps times
  typedef struct {
    request_t rq;
    int       reps;
    bit       fixed;
    result_t  ack;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  request_t    request   = '0;
  logic        full;
  logic        empty;
  logic        pop       = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // mirror of the block state
  cfg_t       base_regs;
  cmd_entry_t cmd_mirror [CMD_SLOTS];
  pal_entry_t pal_mirror [PAL_SLOTS];
  int         cmd_used;
  int         pal_used;

  result_t   due_results [$];
  result_t   step_out [$];
  stim_row_t stim_rows [$];
  int        send_idle  = 0;
  int        recv_stall = 0;
  int        fail_count = 0;

  deferred_video_write_queue_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // acknowledgement with free counts
  function automatic result_t ack_result(bit acc, logic [4:0] cmd_free, logic [3:0] pal_free);
    result_t r = '0;
    r.out_kind = OUT_ACK;
    r.accepted = acc;
    r.cmd_free = cmd_free;
    r.pal_free = pal_free;
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic result_t video_write(logic [15:0] addr, logic [15:0] data);
    result_t r = '0;
    r.out_kind   = OUT_WRITE;
    r.write_addr = addr;
    r.write_data = data;
    return r;
  endfunction

  // results caused by one accepted item, left in step_out
  function automatic void predict_step(request_t rq);
    cmd_entry_t ent;
    pal_entry_t pe;
    result_t    r;
    bit         acc;
    step_out.delete();
    if (rq.action == ACT_ENQUEUE) begin
      acc = 1'b0;
      if (rq.cmd_kind <= KIND_RAW) begin
        if (cmd_used < CMD_SLOTS) begin
          ent.kind   = rq.cmd_kind[1:0];
          ent.slot   = (rq.cmd_kind == KIND_RAW) ? 16'h0 : rq.sprite_slot;
          ent.word_a = (rq.cmd_kind == KIND_HIDE) ? 16'h0 : rq.word_a;
          ent.word_b = (rq.cmd_kind == KIND_POS || rq.cmd_kind == KIND_RAW) ?
                       rq.word_b : 16'h0;
          cmd_mirror[cmd_used] = ent;
          cmd_used++;
          acc = 1'b1;
        end
      end else if (rq.cmd_kind == KIND_PAL) begin
        if (pal_used < PAL_SLOTS && rq.source_addr != 32'h0) begin
          pe.index = rq.palette_index;
          pe.src   = rq.source_addr;
          pal_mirror[pal_used] = pe;
          pal_used++;
          acc = 1'b1;
        end
      end
      step_out.push_back(ack_result(acc, 5'(CMD_SLOTS - cmd_used), 4'(PAL_SLOTS - pal_used)));
    end else begin
      // sprite commands first, as video word writes
      for (int i = 0; i < cmd_used; i++) begin
        ent = cmd_mirror[i];
        case (ent.kind)
          ENT_POS: begin
            step_out.push_back(video_write(16'(base_regs.height_y_base + ent.slot),
                                           ent.word_a));
            step_out.push_back(video_write(16'(base_regs.x_base + ent.slot), ent.word_b));
          end
          ENT_SHRINK: begin
            step_out.push_back(video_write(16'(base_regs.shrink_base + ent.slot),
                                           ent.word_a));
          end
          ENT_HIDE: begin
            step_out.push_back(video_write(16'(base_regs.height_y_base + ent.slot), 16'h0));
          end
          default: begin
            step_out.push_back(video_write(ent.word_a, ent.word_b));
          end
        endcase
      end
      // then one block copy per palette upload
      for (int i = 0; i < pal_used; i++) begin
        pe = pal_mirror[i];
        r = '0;
        r.out_kind  = OUT_COPY;
        r.copy_dest = base_regs.palette_base + 32'(pe.index) * 32;
        r.copy_src  = pe.src;
        step_out.push_back(r);
      end
      cmd_used = 0;
      pal_used = 0;
      step_out.push_back(ack_result(1'b0, 5'(CMD_SLOTS), 4'(PAL_SLOTS)));
    end
  endfunction

  function automatic void add_row(input logic act, input logic [2:0] kind,
                                  input logic [15:0] slot, word_a, word_b,
                                  input logic [7:0] idx, input logic [31:0] src,
                                  input int reps, input bit fixed, input bit acc,
                                  input logic [4:0] cmd_free, input logic [3:0] pal_free);
    stim_row_t row;
    row.rq.action        = act;
    row.rq.cmd_kind      = kind;
    row.rq.sprite_slot   = slot;
    row.rq.word_a        = word_a;
    row.rq.word_b        = word_b;
    row.rq.palette_index = idx;
    row.rq.source_addr   = src;
    row.reps  = reps;
    row.fixed = fixed;
    row.ack   = ack_result(acc, cmd_free, pal_free);
    stim_rows.push_back(row);
  endfunction

  // mostly enqueues of legal kinds, broken up by flushes
  function automatic request_t random_request();
    request_t rq;
    int       pick;
    rq.action        = ACT_ENQUEUE;
    rq.cmd_kind      = KIND_POS;
    rq.sprite_slot   = 16'($urandom);
    rq.word_a        = 16'($urandom);
    rq.word_b        = 16'($urandom);
    rq.palette_index = 8'($urandom);
    rq.source_addr   = $urandom;
    if ($urandom_range(7) == 0) rq.source_addr = 32'h0;
    pick = $urandom_range(99);
    if (pick < 8) begin
      rq.action   = ACT_FLUSH;
      rq.cmd_kind = 3'($urandom);
    end else if (pick < 30) begin
      rq.cmd_kind = KIND_POS;
    end else if (pick < 44) begin
      rq.cmd_kind = KIND_SHRINK;
    end else if (pick < 58) begin
      rq.cmd_kind = KIND_HIDE;
    end else if (pick < 72) begin
      rq.cmd_kind = KIND_RAW;
    end else if (pick < 96) begin
      rq.cmd_kind = KIND_PAL;
    end else begin
      rq.cmd_kind = 3'($urandom_range(7, 5));
    end
    return rq;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("kind=%0d addr=%h data=%h dest=%h src=%h acc=%0d cfree=%0d pfree=%0d last=%0d",
                     r.out_kind, r.write_addr, r.write_data, r.copy_dest, r.copy_src,
                     r.accepted, r.cmd_free, r.pal_free, r.last);
  endfunction

  // one input transfer, after a random gap
  task automatic send_item(input request_t rq, input bit fixed, input result_t ack);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    request <= rq;
    do @(posedge clk); while (full);
    predict_step(rq);
    if (fixed) due_results.push_back(ack);
    else foreach (step_out[k]) due_results.push_back(step_out[k]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SHRINK_BASE:   base_regs.shrink_base   = val[15:0];
      CFG_HEIGHT_Y_BASE: base_regs.height_y_base = val[15:0];
      CFG_X_BASE:        base_regs.x_base        = val[15:0];
      default:           base_regs.palette_base  = val;
    endcase
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(CFG_SHRINK_BASE, 32'(c.shrink_base));
    write_reg(CFG_HEIGHT_Y_BASE, 32'(c.height_y_base));
    write_reg(CFG_X_BASE, 32'(c.x_base));
    write_reg(CFG_PALETTE_BASE, c.palette_base);
    cfg_valid <= 1'b0;
  endtask

  // wait until every expected result has been taken, then let the block settle
  task automatic drain();
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result side: random stalls
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_stall);
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) $display("unexpected result: %s", fmt_result(result));
      end else begin
        want = due_results.pop_front();
        if (want.out_kind !== result.out_kind || want.write_addr !== result.write_addr ||
            want.write_data !== result.write_data || want.copy_dest !== result.copy_dest ||
            want.copy_src !== result.copy_src || want.accepted !== result.accepted ||
            want.cmd_free !== result.cmd_free || want.pal_free !== result.pal_free ||
            want.last !== result.last) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(result));
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    cfg_t c;
    base_regs = '{RST_SHRINK_BASE, RST_HEIGHT_Y_BASE, RST_X_BASE, RST_PALETTE_BASE};
    cmd_used  = 0;
    pal_used  = 0;

    // flush of empty queues
    add_row(ACT_FLUSH, KIND_POS, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0, 1, 1, 0, 16, 8);
    // one of each kind, field extremes
    add_row(ACT_ENQUEUE, KIND_POS, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0, 1, 1, 1, 15, 8);
    add_row(ACT_ENQUEUE, KIND_SHRINK, 16'hFFFF, 16'h1234, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
            1, 1, 1, 14, 8);
    add_row(ACT_ENQUEUE, KIND_HIDE, 16'h7FFF, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0, 1, 1, 1, 13, 8);
    add_row(ACT_ENQUEUE, KIND_RAW, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, 32'h0, 1, 1, 1, 12, 8);
    add_row(ACT_ENQUEUE, KIND_PAL, 16'h0, 16'h0, 16'h0, 8'hFF, 32'hFFFF_FFFF, 1, 1, 1, 12, 7);
    // palette upload with no source is dropped
    add_row(ACT_ENQUEUE, KIND_PAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 32'h0, 1, 1, 0, 12, 7);
    // unknown kinds are ignored
    add_row(ACT_ENQUEUE, 3'd5, 16'h1, 16'h2, 16'h3, 8'h4, 32'h5, 1, 1, 0, 12, 7);
    add_row(ACT_ENQUEUE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
            1, 1, 0, 12, 7);
    add_row(ACT_ENQUEUE, KIND_PAL, 16'h0, 16'h0, 16'h0, 8'h01, 32'h0000_0001, 1, 1, 1, 12, 6);
    add_row(ACT_FLUSH, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0);
    // both queues past full, then the longest flush
    add_row(ACT_ENQUEUE, KIND_POS, 16'h03FF, 16'h5555, 16'hAAAA, 8'h00, 32'h0, 17, 0, 0, 0, 0);
    add_row(ACT_ENQUEUE, KIND_PAL, 16'h0, 16'h0, 16'h0, 8'h80, 32'h8000_0000, 9, 0, 0, 0, 0);
    add_row(ACT_ENQUEUE, KIND_RAW, 16'h0, 16'h4321, 16'h8765, 8'h00, 32'h0, 1, 1, 0, 0, 0);
    add_row(ACT_ENQUEUE, KIND_PAL, 16'h0, 16'h0, 16'h0, 8'h7F, 32'h1234_5678, 1, 1, 0, 0, 0);
    add_row(ACT_FLUSH, KIND_POS, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0, 1, 0, 0, 0, 0);
    add_row(ACT_FLUSH, KIND_PAL, 16'h0, 16'h0, 16'h0, 8'h0, 32'h0, 1, 1, 0, 16, 8);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[n]) begin
      repeat (stim_rows[n].reps) send_item(stim_rows[n].rq, stim_rows[n].fixed, stim_rows[n].ack);
    end

    // random phases, each with its own register setting and idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: c = '1;
        1: c = '0;
        2: begin
          c.shrink_base   = 16'($urandom);
          c.height_y_base = 16'($urandom);
          c.x_base        = 16'($urandom);
          c.palette_base  = $urandom;
        end
        default: c = '{RST_SHRINK_BASE, RST_HEIGHT_Y_BASE, RST_X_BASE, RST_PALETTE_BASE};
      endcase
      write_config(c);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 53; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 53; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      repeat (PHASE_ITEMS) send_item(random_request(), 1'b0, '0);
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
